>>> hdl/baro_pkg.sv
// Shared types, register indexes and constants for the barometer compensation block.
// No dependencies; compiled first.
package baro_pkg;

   localparam int NUM_REGS   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RAW_W      = 24;
   localparam int TEMP_W     = 15;
   localparam int PRES_W     = 18;
   localparam int STEP_W     = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SENS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SENS_TC   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_TC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_LIMIT = 3'd6;

   localparam logic [CSR_DATA_W-1:0] JUMP_LIMIT_RESET = 16'd500;

   localparam logic OP_TEMP = 1'b0;
   localparam logic OP_PRES = 1'b1;

   localparam logic [STEP_W-1:0] TEMP_LAST_STEP = 3'd5;
   localparam logic [STEP_W-1:0] PRES_LAST_STEP = 3'd7;

   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
   localparam logic [PRES_W-1:0] PRES_MAX = 18'd200000;

   typedef struct packed {
      logic              start;     // capture the request payload
      logic              run;       // execute datapath step
      logic [STEP_W-1:0] step;
      logic              load_rsp;  // move result into output register
   } cmd_type;

   function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [18:0] t);
      logic signed [TEMP_W-1:0] r;
      if (t < 19'(TEMP_MIN)) r = TEMP_MIN;
      else if (t > 19'(TEMP_MAX)) r = TEMP_MAX;
      else r = t[TEMP_W-1:0];
      return r;
   endfunction

endpackage

>>> hdl/baro_sensor_compensation.sv
// Top level of the barometer compensation block: controller plus datapath.
// Depends on baro_pkg, baro_ctrl and baro_datapath.
//
//   channel   handshake              payload
//   req       req_valid/req_ready    req_op, req_raw_adc
//   rsp       rsp_valid/rsp_ready    rsp_kind, rsp_temperature, rsp_pressure, rsp_temp_accepted
//   csr       csr_we                 csr_index, csr_wdata
//
// One transaction at a time on a shared 27x27 multiplier: a temperature item takes
// 6 datapath steps and a pressure item 8, followed by a load of the output register.
// A finished result sits in the output register while the next transaction is accepted.
// If rsp_ready stays low the next result waits in the datapath until the output frees.
// Synchronous reset clears control and kept state; calibration registers reset to zero, jump limit to 500.
module baro_sensor_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [baro_pkg::RAW_W-1:0]           req_raw_adc,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_kind,
   output logic signed [baro_pkg::TEMP_W-1:0]   rsp_temperature,
   output logic [baro_pkg::PRES_W-1:0]          rsp_pressure,
   output logic                                 rsp_temp_accepted,
   input  logic                                 csr_we,
   input  logic [baro_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [baro_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import baro_pkg::*;

   cmd_type cmd;

   baro_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   baro_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_raw_adc       (req_raw_adc),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_kind          (rsp_kind),
      .rsp_temperature   (rsp_temperature),
      .rsp_pressure      (rsp_pressure),
      .rsp_temp_accepted (rsp_temp_accepted)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while one is in flight");

   a_temp_no_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == OP_TEMP)) |-> (rsp_pressure == '0))
      else $error("temperature result carries a pressure");

   a_pres_not_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == OP_PRES)) |-> !rsp_temp_accepted)
      else $error("pressure result flags temperature acceptance");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_temperature >= TEMP_MIN) && (rsp_temperature <= TEMP_MAX)))
      else $error("temperature output outside saturation range");
`endif

endmodule

>>> hdl/baro_ctrl.sv
// Sequencing controller: accepts a transaction, steps the datapath, hands off the result.
// Depends on baro_pkg.
module baro_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output baro_pkg::cmd_type  cmd
);
   import baro_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              op_ff, op_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0] last_step;

   assign last_step = (op_ff == OP_PRES) ? PRES_LAST_STEP : TEMP_LAST_STEP;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               op_in     = req_op;
               step_in   = '0;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            cmd.run = 1'b1;
            if (step_ff == last_step) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         op_ff        <= OP_TEMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/baro_datapath.sv
// Datapath: calibration registers, shared multiplier, compensation state and result registers.
// Depends on baro_pkg; driven by baro_ctrl commands.
module baro_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  baro_pkg::cmd_type                    cmd,
   input  logic                                 req_op,
   input  logic [baro_pkg::RAW_W-1:0]           req_raw_adc,
   input  logic                                 csr_we,
   input  logic [baro_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [baro_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_kind,
   output logic signed [baro_pkg::TEMP_W-1:0]   rsp_temperature,
   output logic [baro_pkg::PRES_W-1:0]          rsp_pressure,
   output logic                                 rsp_temp_accepted
);
   import baro_pkg::*;

   logic [CSR_DATA_W-1:0] coeff_ff [NUM_REGS];

   logic               op_ff;
   logic [RAW_W-1:0]   raw_ff;
   logic signed [26:0] mul_a, mul_b;
   logic signed [53:0] prod_ff;

   // temperature working values
   logic signed [25:0] dt_ff;
   logic signed [17:0] q_ff;
   logic signed [18:0] temp1_ff;
   logic [17:0]        t2_ff;
   logic [34:0]        a_ff;

   // kept state
   logic signed [25:0] temp_difference_ff;
   logic [39:0]        offset_correction_ff, sens_correction_ff;
   logic signed [18:0] accepted_temp_ff;
   logic               seen_first_ff;

   // pressure working values
   logic signed [40:0] off_ff, sens_ff;
   logic [44:0]        lo_ff;
   logic signed [63:0] full_ff;
   logic signed [43:0] x_ff;

   // result hold and output registers
   logic                     res_kind_ff, res_acc_ff;
   logic signed [TEMP_W-1:0] res_temp_ff;
   logic [PRES_W-1:0]        res_pres_ff;
   logic                     rsp_kind_ff, rsp_acc_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic [PRES_W-1:0]        rsp_pres_ff;

   logic is_temp, is_pres;
   assign is_temp = cmd.run && (op_ff == OP_TEMP);
   assign is_pres = cmd.run && (op_ff == OP_PRES);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (op_ff == OP_TEMP) begin
         unique case (cmd.step)
            3'd1: begin
               mul_a = 27'(dt_ff);
               mul_b = $signed({11'd0, coeff_ff[REG_TEMP_SLOPE]});
            end
            3'd2: begin
               mul_a = 27'(dt_ff);
               mul_b = 27'(dt_ff);
            end
            3'd3: begin
               mul_a = 27'(q_ff);
               mul_b = 27'(q_ff);
            end
            3'd4: begin
               mul_a = 27'(temp1_ff) + 27'sd1500;
               mul_b = 27'(temp1_ff) + 27'sd1500;
            end
            default: ;
         endcase
      end else begin
         unique case (cmd.step)
            3'd0: begin
               mul_a = $signed({11'd0, coeff_ff[REG_OFFSET_TC]});
               mul_b = 27'(temp_difference_ff);
            end
            3'd1: begin
               mul_a = $signed({11'd0, coeff_ff[REG_SENS_TC]});
               mul_b = 27'(temp_difference_ff);
            end
            3'd3: begin
               mul_a = $signed({3'd0, raw_ff});
               mul_b = $signed({6'd0, sens_ff[20:0]});
            end
            3'd4: begin
               mul_a = $signed({3'd0, raw_ff});
               mul_b = 27'($signed(sens_ff[40:21]));
            end
            default: ;
         endcase
      end
   end

   // truncating divides: bias negative values before the arithmetic shift
   logic signed [53:0] q_sum, d7_sum, d8_sum;
   logic signed [63:0] f_sum;
   logic signed [43:0] p_sum;
   assign q_sum  = (prod_ff + $signed({31'd0, {23{prod_ff[53]}}})) >>> 23;
   assign d7_sum = (prod_ff + $signed({47'd0, {7{prod_ff[53]}}})) >>> 7;
   assign d8_sum = (prod_ff + $signed({46'd0, {8{prod_ff[53]}}})) >>> 8;
   assign f_sum  = (full_ff + $signed({43'd0, {21{full_ff[63]}}})) >>> 21;
   assign p_sum  = (x_ff + $signed({29'd0, {15{x_ff[43]}}})) >>> 15;

   // second-order correction and jump check
   logic               lt20, lt15, accept;
   logic [35:0]        b_sq;
   logic [39:0]        a5, b7, b11, off2, sens2;
   logic signed [18:0] temp_final, acc_next;
   logic signed [19:0] diff;
   logic [19:0]        abs_diff;

   always_comb begin
      lt20  = q_ff[17];
      lt15  = temp1_ff < -19'sd1500;
      b_sq  = prod_ff[35:0];
      a5    = 40'(a_ff) + (40'(a_ff) << 2);
      b7    = (40'(b_sq) << 3) - 40'(b_sq);
      b11   = (40'(b_sq) << 3) + (40'(b_sq) << 1) + 40'(b_sq);
      off2  = '0;
      sens2 = '0;
      if (lt20) begin
         off2  = (a5 >> 1) + (lt15 ? b7 : 40'd0);
         sens2 = (a5 >> 2) + (lt15 ? (b11 >> 1) : 40'd0);
      end
      temp_final = temp1_ff - (lt20 ? $signed({1'b0, t2_ff}) : 19'sd0);
      diff       = 20'(temp_final) - 20'(accepted_temp_ff);
      abs_diff   = diff[19] ? 20'(-diff) : 20'(diff);
      accept     = !seen_first_ff || (abs_diff < {4'd0, coeff_ff[REG_JUMP_LIMIT]});
      acc_next   = accept ? temp_final : accepted_temp_ff;
   end

   logic [PRES_W-1:0] pres_sat;
   always_comb begin
      if (p_sum[43]) pres_sat = '0;
      else if (p_sum > 44'sd200000) pres_sat = PRES_MAX;
      else pres_sat = p_sum[PRES_W-1:0];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            coeff_ff[i] <= (i == REG_JUMP_LIMIT) ? JUMP_LIMIT_RESET : '0;
      end else if (csr_we && (csr_index <= REG_JUMP_LIMIT)) begin
         coeff_ff[csr_index] <= csr_wdata;
      end
   end

   // kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_difference_ff   <= '0;
         offset_correction_ff <= '0;
         sens_correction_ff   <= '0;
         accepted_temp_ff     <= '0;
         seen_first_ff        <= 1'b0;
      end else if (is_temp && (cmd.step == TEMP_LAST_STEP)) begin
         temp_difference_ff   <= dt_ff;
         offset_correction_ff <= off2;
         sens_correction_ff   <= sens2;
         accepted_temp_ff     <= acc_next;
         seen_first_ff        <= 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         raw_ff <= req_raw_adc;
      end
      if (cmd.run) prod_ff <= mul_a * mul_b;
      if (is_temp) begin
         unique case (cmd.step)
            3'd0: dt_ff <= $signed({2'd0, raw_ff}) - $signed({2'd0, coeff_ff[REG_REF_TEMP], 8'd0});
            3'd2: begin
               q_ff     <= q_sum[17:0];
               temp1_ff <= $signed(q_sum[18:0]) + 19'sd2000;
            end
            3'd3: t2_ff <= prod_ff[48:31];
            3'd4: a_ff  <= prod_ff[34:0];
            3'd5: begin
               res_kind_ff <= OP_TEMP;
               res_temp_ff <= sat_temp(acc_next);
               res_pres_ff <= '0;
               res_acc_ff  <= accept;
            end
            default: ;
         endcase
      end
      if (is_pres) begin
         unique case (cmd.step)
            3'd1: off_ff <= $signed({9'd0, coeff_ff[REG_OFFSET], 16'd0}) + d7_sum[40:0]
                            - $signed({1'b0, offset_correction_ff});
            3'd2: sens_ff <= $signed({10'd0, coeff_ff[REG_SENS], 15'd0}) + d8_sum[40:0]
                             - $signed({1'b0, sens_correction_ff});
            3'd4: lo_ff <= prod_ff[44:0];
            3'd5: full_ff <= (64'(prod_ff) <<< 21) + $signed({19'd0, lo_ff});
            3'd6: x_ff <= f_sum[43:0] - 44'(off_ff);
            3'd7: begin
               res_kind_ff <= OP_PRES;
               res_temp_ff <= sat_temp(accepted_temp_ff);
               res_pres_ff <= pres_sat;
               res_acc_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_temp_ff <= res_temp_ff;
         rsp_pres_ff <= res_pres_ff;
         rsp_acc_ff  <= res_acc_ff;
      end
   end

   assign rsp_kind          = rsp_kind_ff;
   assign rsp_temperature   = rsp_temp_ff;
   assign rsp_pressure      = rsp_pres_ff;
   assign rsp_temp_accepted = rsp_acc_ff;

endmodule
